[rtl/core/ipap_pkg.sv]
`default_nettype none
package ipap_pkg;

  localparam int ADDR_BYTES = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [7:0] POS_LIMIT = 8'd255;

  typedef logic [8:0] flags_t;

  localparam flags_t F_XDIGIT  = 9'h001;
  localparam flags_t F_DIGIT   = 9'h002;
  localparam flags_t F_C1      = 9'h004;
  localparam flags_t F_C2      = 9'h008;
  localparam flags_t F_C12     = 9'h010;
  localparam flags_t F_DOT     = 9'h020;
  localparam flags_t F_DELIM   = 9'h040;
  localparam flags_t F_NULL    = 9'h080;
  localparam flags_t F_UNKNOWN = 9'h100;
  localparam flags_t F_COLONS  = F_C1 | F_C2 | F_C12;

  localparam logic [1:0] CFG_DELIM_CHAR  = 2'd0;
  localparam logic [1:0] CFG_DELIM_ANY   = 2'd1;
  localparam logic [1:0] CFG_FAMILY_MODE = 2'd2;

  typedef struct packed {
    logic [7:0] delimiter_char;
    logic       delimiter_any;
  } front_cfg_t;

  typedef struct packed {
    logic       start;
    flags_t     cls;
    logic [3:0] val;
  } q_item_t;

endpackage
`default_nettype wire

[rtl/core/ip_address_text_parser_unit.sv]
`default_nettype none
// Converts IPv6 (with optional dotted IPv4 tail) or dotted IPv4 address text,
// one character per item with start_req on the first, into a 128-bit address,
// a success flag and the character position where parsing stopped. One item
// is taken every cycle while the queue has room; the text's last character
// is registered in the queue and its result in the parser's output register.
// A classifier feeds a four-entry queue; the parser drains it at one character
// per cycle while no result waits; the parser and the consumer set the rate.
module ip_address_text_parser_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // char_in
  input  wire logic         s_tuser,   // start_req
  input  wire logic         s_tlast,   // end_of_text
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata,   // stop_index, addr_lower, addr_upper (MSB first)
  output logic              m_tuser,   // ok
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [7:0]   cfg_data
);

  ipap_pkg::front_cfg_t front_cfg;
  logic                 family_mode;
  ipap_pkg::q_item_t    front_item;
  ipap_pkg::q_item_t    head_item;
  logic                 q_not_full;
  logic                 q_not_empty;
  logic                 q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_cfg.delimiter_char <= 8'd0;
      front_cfg.delimiter_any <= 1'b0;
      family_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ipap_pkg::CFG_DELIM_CHAR:  front_cfg.delimiter_char <= cfg_data;
        ipap_pkg::CFG_DELIM_ANY:   front_cfg.delimiter_any <= cfg_data[0];
        ipap_pkg::CFG_FAMILY_MODE: family_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_tready = q_not_full;

  ipap_front u_front (
    .cfg         (front_cfg),
    .start_req   (s_tuser),
    .char_in     (s_tdata),
    .end_of_text (s_tlast),
    .item        (front_item)
  );

  ipap_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && q_not_full),
    .push_item (front_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  ipap_back u_back (
    .clk         (clk),
    .rst         (rst),
    .family_mode (family_mode),
    .q_valid     (q_not_empty),
    .item        (head_item),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule
`default_nettype wire

[rtl/core/ipap_front.sv]
`default_nettype none
module ipap_front (
  input  wire ipap_pkg::front_cfg_t cfg,
  input  wire logic                 start_req,
  input  wire logic [7:0]           char_in,
  input  wire logic                 end_of_text,
  output ipap_pkg::q_item_t         item
);

  logic [7:0] ch;

  assign ch = end_of_text ? 8'd0 : char_in;

  always_comb begin
    item.start = start_req;
    item.val = 4'd0;
    if ((!cfg.delimiter_any && ch == cfg.delimiter_char) || ch == 8'd0) begin
      item.cls = ipap_pkg::F_DELIM;
    end else if (ch == 8'h3a) begin
      item.cls = ipap_pkg::F_COLONS;
    end else if (ch == 8'h2e) begin
      item.cls = ipap_pkg::F_DOT;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      item.cls = ipap_pkg::F_XDIGIT | ipap_pkg::F_DIGIT;
      item.val = ch[3:0];
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      item.cls = ipap_pkg::F_XDIGIT;
      item.val = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      item.cls = ipap_pkg::F_XDIGIT;
      item.val = 4'(ch - 8'h37);
    end else if (cfg.delimiter_any) begin
      item.cls = ipap_pkg::F_DELIM;
    end else begin
      item.cls = ipap_pkg::F_UNKNOWN;
    end
  end

endmodule
`default_nettype wire

[rtl/core/ipap_queue.sv]
`default_nettype none
module ipap_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ipap_pkg::q_item_t push_item,
  output logic                   not_full,
  input  wire logic              pop,
  output logic                   not_empty,
  output ipap_pkg::q_item_t      head_item
);

  localparam int PW = $clog2(ipap_pkg::QUEUE_DEPTH);

  ipap_pkg::q_item_t entries [ipap_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign not_full  = count != (PW+1)'(ipap_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/ipap_back.sv]
`default_nettype none
module ipap_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              family_mode,
  input  wire logic              q_valid,
  input  wire ipap_pkg::q_item_t item,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [135:0]           m_tdata,   // stop_index, addr_lower, addr_upper (MSB first)
  output logic                   m_tuser    // ok
);

  logic [7:0]  buffer [ipap_pkg::ADDR_BYTES];
  logic [4:0]  wr_pos;
  logic [4:0]  gap_pos;
  logic        gap_seen;
  logic [15:0] hex_word;
  ipap_pkg::flags_t allowed;
  logic [11:0] dec_word;
  logic        all_dec;
  logic        has_digit;
  logic        in_tail;
  logic        ipv4_only;
  logic [2:0]  octets;
  logic [7:0]  char_pos;
  logic [7:0]  bad_pos;
  logic        finished;

  logic [7:0]  buffer_next [ipap_pkg::ADDR_BYTES];
  logic [4:0]  wr_pos_next;
  logic [4:0]  gap_pos_next;
  logic        gap_seen_next;
  logic [15:0] hex_word_next;
  ipap_pkg::flags_t allowed_next;
  logic [11:0] dec_word_next;
  logic        all_dec_next;
  logic        has_digit_next;
  logic        in_tail_next;
  logic        ipv4_only_next;
  logic [2:0]  octets_next;
  logic [7:0]  char_pos_next;
  logic [7:0]  bad_pos_next;
  logic        finished_next;

  logic        emit;
  logic        res_ok;
  logic [7:0]  res_pos;
  logic [63:0] res_upper;
  logic [63:0] res_lower;
  logic        take;

  assign take  = q_valid && (!m_tvalid || m_tready);
  assign q_pop = take;

  always_comb begin
    ipap_pkg::flags_t cls;
    logic [5:0]  idx;
    logic [11:0] dec_calc;
    logic [2:0]  oct_inc;
    cls = item.cls;
    if (item.start) begin
      for (int i = 0; i < ipap_pkg::ADDR_BYTES; i++) begin
        buffer_next[i] = 8'd0;
      end
      wr_pos_next = '0;
      gap_pos_next = '0;
      gap_seen_next = 1'b0;
      hex_word_next = '0;
      allowed_next = ipap_pkg::F_C12 | ipap_pkg::F_XDIGIT | ipap_pkg::F_NULL;
      dec_word_next = '0;
      all_dec_next = 1'b1;
      has_digit_next = 1'b0;
      octets_next = '0;
      char_pos_next = '0;
      bad_pos_next = '0;
      finished_next = 1'b0;
      ipv4_only_next = !family_mode;
      in_tail_next = !family_mode;
    end else begin
      buffer_next = buffer;
      wr_pos_next = wr_pos;
      gap_pos_next = gap_pos;
      gap_seen_next = gap_seen;
      hex_word_next = hex_word;
      allowed_next = allowed;
      dec_word_next = dec_word;
      all_dec_next = all_dec;
      has_digit_next = has_digit;
      octets_next = octets;
      char_pos_next = char_pos;
      bad_pos_next = bad_pos;
      finished_next = finished;
      ipv4_only_next = ipv4_only;
      in_tail_next = in_tail;
    end
    emit = 1'b0;
    res_ok = 1'b0;
    res_pos = char_pos_next;
    dec_calc = 12'((dec_word_next << 3) + (dec_word_next << 1) + {8'd0, item.val});
    idx = (ipv4_only_next ? 6'd0 : {1'b0, wr_pos_next}) + {3'd0, octets_next};
    oct_inc = octets_next + 3'd1;

    if (item.start || !finished) begin
      if (in_tail_next) begin
        if (~|(cls & (ipap_pkg::F_DIGIT | ipap_pkg::F_DOT | ipap_pkg::F_DELIM
                      | ipap_pkg::F_COLONS))) begin
          emit = 1'b1;
        end else if (|(cls & (ipap_pkg::F_DOT | ipap_pkg::F_DELIM
                              | ipap_pkg::F_COLONS))) begin
          if (!has_digit_next) begin
            emit = 1'b1;
          end
          if (idx < 6'(ipap_pkg::ADDR_BYTES)) begin
            buffer_next[idx[3:0]] = dec_word_next[7:0];
          end
          octets_next = oct_inc;
          dec_word_next = '0;
          has_digit_next = 1'b0;
          if (|(cls & (ipap_pkg::F_DELIM | ipap_pkg::F_COLONS))) begin
            emit = 1'b1;
            if (oct_inc == 3'd4 && has_digit) begin
              res_ok = 1'b1;
              if (!ipv4_only_next) begin
                wr_pos_next = wr_pos_next + 5'd4;
              end
            end
          end else if (oct_inc[2]) begin
            emit = 1'b1;
          end
        end else begin
          dec_word_next = dec_calc;
          has_digit_next = 1'b1;
          if (dec_calc > 12'd255) begin
            emit = 1'b1;
          end
        end
        if (item.start) begin
          // start clears has_digit; repeat the check on the cleared value
          if (|(cls & (ipap_pkg::F_DELIM | ipap_pkg::F_COLONS | ipap_pkg::F_DOT))) begin
            res_ok = 1'b0;
          end
        end
      end else begin
        if (~|(cls & allowed_next)) begin
          emit = 1'b1;
        end else if (|(cls & (ipap_pkg::F_DELIM | ipap_pkg::F_COLONS))) begin
          if (~|(allowed_next & ipap_pkg::F_NULL) && wr_pos_next <= 5'd14) begin
            buffer_next[wr_pos_next[3:0]] = hex_word_next[15:8];
            buffer_next[4'(wr_pos_next[3:0] + 4'd1)] = hex_word_next[7:0];
            wr_pos_next = wr_pos_next + 5'd2;
          end
          hex_word_next = '0;
          if (|(cls & ipap_pkg::F_DELIM)) begin
            emit = 1'b1;
            res_ok = 1'b1;
          end
          case (allowed_next & ipap_pkg::F_COLONS)
            ipap_pkg::F_C2: begin
              gap_pos_next = wr_pos_next;
              gap_seen_next = 1'b1;
              allowed_next = ipap_pkg::F_XDIGIT | ipap_pkg::F_DELIM;
              if (wr_pos_next >= 5'(ipap_pkg::ADDR_BYTES)) begin
                allowed_next = allowed_next | ipap_pkg::F_NULL;
              end
            end
            ipap_pkg::F_C1 | ipap_pkg::F_C12: begin
              allowed_next = ipap_pkg::F_XDIGIT | ipap_pkg::F_C2;
            end
            ipap_pkg::F_C1: begin
              allowed_next = ipap_pkg::F_XDIGIT;
            end
            ipap_pkg::F_C12: begin
              allowed_next = ipap_pkg::F_C2;
            end
            default: begin
              allowed_next = '0;
            end
          endcase
          dec_word_next = '0;
          all_dec_next = 1'b1;
          has_digit_next = 1'b0;
        end else if (|(cls & ipap_pkg::F_DOT)) begin
          if (!all_dec_next) begin
            emit = 1'b1;
            res_pos = bad_pos_next;
          end else if (!has_digit_next) begin
            emit = 1'b1;
          end
          if (wr_pos_next < 5'(ipap_pkg::ADDR_BYTES)) begin
            buffer_next[wr_pos_next[3:0]] = dec_word_next[7:0];
          end
          octets_next = 3'd1;
          dec_word_next = '0;
          has_digit_next = 1'b0;
          in_tail_next = 1'b1;
        end else begin
          if (all_dec_next) begin
            if (~|(cls & ipap_pkg::F_DIGIT)) begin
              bad_pos_next = char_pos_next;
              all_dec_next = 1'b0;
            end else begin
              dec_word_next = dec_calc;
              has_digit_next = 1'b1;
              if (dec_calc > 12'd255) begin
                bad_pos_next = char_pos_next;
                all_dec_next = 1'b0;
              end
            end
          end
          hex_word_next = {hex_word_next[11:0], item.val};
          allowed_next = ipap_pkg::F_C1 | ipap_pkg::F_DELIM;
          if (hex_word_next[15:12] == 4'd0) begin
            allowed_next = allowed_next | ipap_pkg::F_XDIGIT;
          end
          if (!gap_seen_next && wr_pos_next < 5'd14) begin
            allowed_next = (allowed_next | ipap_pkg::F_C12) & ~ipap_pkg::F_DELIM;
          end
          if (wr_pos_next >= 5'd14) begin
            allowed_next = allowed_next & ~(ipap_pkg::F_C1 | ipap_pkg::F_C12);
          end
        end
        if (!(|(cls & allowed)) && !item.start) begin
          allowed_next = allowed_next;
        end
        if (~|(cls & ipap_pkg::F_DOT)) begin
          if ((gap_seen_next && wr_pos_next < 5'd12) || wr_pos_next == 5'd12) begin
            allowed_next = allowed_next | ipap_pkg::F_DOT;
          end
          if (wr_pos_next >= 5'(ipap_pkg::ADDR_BYTES)) begin
            allowed_next = allowed_next & ~(ipap_pkg::F_XDIGIT | ipap_pkg::F_COLONS);
          end
        end
      end
      if (char_pos_next < ipap_pkg::POS_LIMIT) begin
        char_pos_next = char_pos_next + 8'd1;
      end
      if (emit) begin
        finished_next = 1'b1;
      end
    end
  end

  always_comb begin
    logic [7:0] a [ipap_pkg::ADDR_BYTES];
    logic [4:0] d;
    logic [4:0] g;
    logic [4:0] tail;
    logic [4:0] src;
    d = (wr_pos_next > 5'(ipap_pkg::ADDR_BYTES)) ? 5'(ipap_pkg::ADDR_BYTES) : wr_pos_next;
    g = (gap_pos_next > d) ? d : gap_pos_next;
    tail = d - g;
    for (int i = 0; i < ipap_pkg::ADDR_BYTES; i++) begin
      src = 5'(i) + d - 5'(ipap_pkg::ADDR_BYTES);
      a[i] = 8'd0;
      if (res_ok && ipv4_only_next) begin
        if (i >= 12) begin
          a[i] = buffer_next[i - 12];
        end
      end else if (res_ok) begin
        if (!gap_seen_next || 5'(i) < g) begin
          a[i] = buffer_next[i];
        end else if (5'(i) >= 5'(ipap_pkg::ADDR_BYTES) - tail) begin
          a[i] = buffer_next[src[3:0]];
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res_upper[63 - 8*i -: 8] = a[i];
      res_lower[63 - 8*i -: 8] = a[8 + i];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buffer <= buffer_next;
      wr_pos <= wr_pos_next;
      gap_pos <= gap_pos_next;
      gap_seen <= gap_seen_next;
      hex_word <= hex_word_next;
      allowed <= allowed_next;
      dec_word <= dec_word_next;
      all_dec <= all_dec_next;
      has_digit <= has_digit_next;
      in_tail <= in_tail_next;
      ipv4_only <= ipv4_only_next;
      octets <= octets_next;
      char_pos <= char_pos_next;
      bad_pos <= bad_pos_next;
    end
    if (take && emit) begin
      m_tdata <= {res_pos, res_lower, res_upper};
      m_tuser <= res_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finished <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        finished <= finished_next;
      end
      if (take && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none
module testbench;
  import ipap_pkg::*;

  localparam int PHASES = 7;
  localparam int PER_PHASE = 210;
  localparam int CALM_TAIL = 200;
  localparam int SETTLE = 16;
  localparam int STUCK_LIMIT = 3000;

  typedef struct packed {
    logic        ok;
    logic [63:0] upper;
    logic [63:0] lower;
    logic [7:0]  stop;
  } parse_t;

  class parse_scoreboard;
    logic [7:0]  delim_char;
    logic        delim_any;
    logic        family;
    logic [7:0]  buf_bytes [16];
    logic [4:0]  wr_pos;
    logic [4:0]  gap_pos;
    logic        gap_seen;
    logic [15:0] hex_word;
    logic [15:0] dec_word;
    flags_t      allowed;
    logic        all_dec;
    logic        has_digit;
    logic        in_tail;
    logic        v4_only;
    logic [2:0]  octets;
    logic [7:0]  char_pos;
    logic [7:0]  bad_pos;
    logic        done;
    parse_t      parsed_addrs[$];
    int          errors;

    function new();
      delim_char = 8'd0;
      delim_any = 1'b0;
      family = 1'b1;
      errors = 0;
      clear();
      v4_only = 1'b0;
      in_tail = 1'b0;
      done = 1'b1;
    endfunction

    function void clear();
      foreach (buf_bytes[i]) buf_bytes[i] = 8'd0;
      wr_pos = 5'd0;
      gap_pos = 5'd0;
      gap_seen = 1'b0;
      hex_word = 16'd0;
      dec_word = 16'd0;
      allowed = F_C12 | F_XDIGIT | F_NULL;
      all_dec = 1'b1;
      has_digit = 1'b0;
      octets = 3'd0;
      char_pos = 8'd0;
      bad_pos = 8'd0;
      done = 1'b0;
      v4_only = (family == 1'b0);
      in_tail = v4_only;
    endfunction

    function flags_t classify_char(logic [7:0] ch, output logic [3:0] val);
      val = 4'd0;
      if ((!delim_any && ch == delim_char) || ch == 8'd0) return F_DELIM;
      if (ch == ":") return F_COLONS;
      if (ch == ".") return F_DOT;
      if (ch >= "0" && ch <= "9") begin
        val = 4'(ch - "0");
        return F_XDIGIT | F_DIGIT;
      end
      if (ch >= "a" && ch <= "f") begin
        val = 4'(ch - "a" + 8'd10);
        return F_XDIGIT;
      end
      if (ch >= "A" && ch <= "F") begin
        val = 4'(ch - "A" + 8'd10);
        return F_XDIGIT;
      end
      if (delim_any) return F_DELIM;
      return F_UNKNOWN;
    endfunction

    function void step_pos();
      if (char_pos < POS_LIMIT) char_pos = char_pos + 8'd1;
    endfunction

    function void close_parse(logic ok, logic [7:0] pos);
      logic [7:0] a [16];
      int d, g, tl, i;
      parse_t r;
      for (i = 0; i < 16; i++) a[i] = 8'd0;
      if (ok && v4_only) begin
        for (i = 0; i < 4; i++) a[12 + i] = buf_bytes[i];
      end else if (ok) begin
        d = (int'(wr_pos) > 16) ? 16 : int'(wr_pos);
        g = (int'(gap_pos) > d) ? d : int'(gap_pos);
        tl = d - g;
        for (i = 0; i < 16; i++) begin
          if (!gap_seen) a[i] = buf_bytes[i];
          else if (i < g) a[i] = buf_bytes[i];
          else if (i >= 16 - tl) a[i] = buf_bytes[i - (16 - tl) + g];
        end
      end
      r.ok = ok;
      r.upper = 64'd0;
      r.lower = 64'd0;
      for (i = 0; i < 8; i++) begin
        r.upper = {r.upper[55:0], a[i]};
        r.lower = {r.lower[55:0], a[8 + i]};
      end
      r.stop = pos;
      parsed_addrs.push_back(r);
      done = 1'b1;
    endfunction

    function void tail_char(flags_t cls, logic [3:0] val);
      int idx;
      if ((cls & (F_DIGIT | F_DOT | F_DELIM | F_COLONS)) == 0) begin
        close_parse(1'b0, char_pos);
        return;
      end
      if ((cls & (F_DOT | F_DELIM | F_COLONS)) != 0) begin
        idx = (v4_only ? 0 : int'(wr_pos)) + int'(octets);
        if (!has_digit) begin
          close_parse(1'b0, char_pos);
          return;
        end
        if (idx < 16) buf_bytes[idx] = dec_word[7:0];
        octets = octets + 3'd1;
        dec_word = 16'd0;
        has_digit = 1'b0;
        if ((cls & (F_DELIM | F_COLONS)) != 0) begin
          if (octets != 3'd4) begin
            close_parse(1'b0, char_pos);
            return;
          end
          if (!v4_only) wr_pos = wr_pos + 5'd4;
          close_parse(1'b1, char_pos);
          return;
        end
        if (octets >= 3'd4) begin
          close_parse(1'b0, char_pos);
          return;
        end
      end else begin
        dec_word = 16'(dec_word * 16'd10 + {12'd0, val});
        has_digit = 1'b1;
        if (dec_word > 255) begin
          close_parse(1'b0, char_pos);
          return;
        end
      end
      step_pos();
    endfunction

    function void v6_char(flags_t cls, logic [3:0] val);
      if ((cls & allowed) == 0) begin
        close_parse(1'b0, char_pos);
        return;
      end
      if ((cls & (F_DELIM | F_COLONS)) != 0) begin
        if ((allowed & F_NULL) == 0 && wr_pos + 2 <= 16) begin
          buf_bytes[wr_pos] = hex_word[15:8];
          buf_bytes[wr_pos + 1] = hex_word[7:0];
          wr_pos = wr_pos + 5'd2;
        end
        hex_word = 16'd0;
        if ((cls & F_DELIM) != 0) begin
          close_parse(1'b1, char_pos);
          return;
        end
        case (allowed & F_COLONS)
          F_C2: begin
            gap_pos = wr_pos;
            gap_seen = 1'b1;
            allowed = F_XDIGIT | F_DELIM;
            if (gap_pos >= 16) allowed = allowed | F_NULL;
          end
          F_C1 | F_C12: allowed = F_XDIGIT | F_C2;
          F_C1: allowed = F_XDIGIT;
          F_C12: allowed = F_C2;
          default: allowed = '0;
        endcase
        dec_word = 16'd0;
        all_dec = 1'b1;
        has_digit = 1'b0;
      end else if ((cls & F_DOT) != 0) begin
        if (!all_dec) begin
          close_parse(1'b0, bad_pos);
          return;
        end
        if (!has_digit) begin
          close_parse(1'b0, char_pos);
          return;
        end
        if (wr_pos < 16) buf_bytes[wr_pos] = dec_word[7:0];
        octets = 3'd1;
        dec_word = 16'd0;
        has_digit = 1'b0;
        in_tail = 1'b1;
        step_pos();
        return;
      end else begin
        if (all_dec) begin
          if ((cls & F_DIGIT) == 0) begin
            bad_pos = char_pos;
            all_dec = 1'b0;
          end else begin
            dec_word = 16'(dec_word * 16'd10 + {12'd0, val});
            has_digit = 1'b1;
            if (dec_word > 255) begin
              bad_pos = char_pos;
              all_dec = 1'b0;
            end
          end
        end
        hex_word = {hex_word[11:0], val};
        allowed = F_C1 | F_DELIM;
        if (hex_word[15:12] == 4'd0) allowed = allowed | F_XDIGIT;
        if (!gap_seen && wr_pos + 2 < 16) begin
          allowed = allowed | F_C12;
          allowed = allowed & ~F_DELIM;
        end
        if (wr_pos + 2 >= 16) allowed = allowed & ~(F_C1 | F_C12);
      end
      if ((gap_seen && wr_pos + 4 < 16) || wr_pos + 4 == 16) allowed = allowed | F_DOT;
      if (wr_pos >= 16) allowed = allowed & ~(F_XDIGIT | F_COLONS);
      step_pos();
    endfunction

    function void take_char(logic st, logic [7:0] ch, logic eot);
      flags_t cls;
      logic [3:0] val;
      if (st) clear();
      else if (done) return;
      cls = classify_char(eot ? 8'd0 : ch, val);
      if (in_tail) tail_char(cls, val);
      else v6_char(cls, val);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_parse(logic ok, logic [63:0] up, logic [63:0] lo, logic [7:0] stop);
      parse_t w;
      if (parsed_addrs.size() == 0) begin
        report("address result with nothing pending");
        return;
      end
      w = parsed_addrs.pop_front();
      if (ok !== w.ok) report($sformatf("ok got %b want %b", ok, w.ok));
      if (up !== w.upper) report($sformatf("addr_upper got %h want %h", up, w.upper));
      if (lo !== w.lower) report($sformatf("addr_lower got %h want %h", lo, w.lower));
      if (stop !== w.stop) report($sformatf("stop_index got %0d want %0d", stop, w.stop));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'd0;
  logic         s_tuser = 1'b0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = CFG_DELIM_CHAR;
  logic [7:0]   cfg_data = 8'd0;

  parse_scoreboard sb = new();
  logic [7:0] txt[$];
  int sent = 0;
  bit quiet = 1'b0;
  int src_rate = 0;
  int sink_rate = 0;
  int stall_left = 0;
  int stuck = 0;

  logic [7:0] ph_dc [PHASES] = '{8'h00, 8'hFF, 8'h20, 8'h2C, 8'hFF, 8'h3A, 8'h61};
  logic       ph_da [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
  logic       ph_fm [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  string v6_cases[] = '{"::", "::1", "1::", "ffff:FFFF:0:0:0:0:0:abcd", "1:2:3:4:5:6:7:8:9",
    "::ffff:192.168.1.255", "1:2:3:4:5:6:1.2.3.4", "::1.2.3", "::256.1.1.1", "::1a.2.3.4",
    "::1..2.3", "::1.2.3.4:", "1:::2", ":1", "g", "", "12345", "fe80::0:1"};
  string v4_cases[] = '{"0.0.0.0", "255.255.255.255", "1.2.3", "1.2.3.4.5", "256.1.1.1",
    "1.2.3.4:", "01.002.3.4", ".1.2.3", "1.2.3.a"};

  ip_address_text_parser_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < sink_rate) begin
      stall_left = $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
    if ($urandom_range(0, 63) == 0) sink_rate = 10 * $urandom_range(0, 3);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_parse(m_tuser, m_tdata[63:0], m_tdata[127:64], m_tdata[135:128]);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck == STUCK_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(logic st, logic [7:0] ch, logic eot, bit counted);
    if (!quiet && $urandom_range(0, 99) < src_rate) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= st;
    s_tdata <= ch;
    s_tlast <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_char(st, ch, eot);
    if (counted) sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.parsed_addrs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] dc, logic da, logic fm);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DELIM_CHAR;
    cfg_data <= dc;
    @(posedge clk);
    cfg_index <= CFG_DELIM_ANY;
    cfg_data <= {7'd0, da};
    @(posedge clk);
    cfg_index <= CFG_FAMILY_MODE;
    cfg_data <= {7'd0, fm};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.delim_char = dc;
    sb.delim_any = da;
    sb.family = fm;
  endtask

  function automatic bit addr_char(logic [7:0] ch);
    return (ch >= "0" && ch <= "9") || (ch >= "a" && ch <= "f") ||
           (ch >= "A" && ch <= "F") || ch == ":" || ch == ".";
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic void put_hex_word();
    string digits = "0123456789abcdefABCDEF";
    int hi;
    hi = ($urandom_range(0, 3) == 0) ? 9 : 21;
    if ($urandom_range(0, 149) == 0) repeat ($urandom_range(250, 300)) txt.push_back("0");
    repeat ($urandom_range(1, 4)) txt.push_back(digits[$urandom_range(0, hi)]);
  endfunction

  function automatic void put_dotted();
    int v;
    for (int i = 0; i < 4; i++) begin
      if (i > 0) txt.push_back(".");
      v = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
      if ($urandom_range(0, 15) == 0) txt.push_back("0");
      put_str($sformatf("%0d", v));
    end
  endfunction

  function automatic void put_v6();
    int n, words, gap_at;
    bit dotted;
    dotted = ($urandom_range(0, 3) == 0);
    n = dotted ? 6 : 8;
    if ($urandom_range(0, 2) == 0) begin
      words = n;
      gap_at = -1;
    end else begin
      words = $urandom_range(0, n - 1);
      gap_at = $urandom_range(0, words);
    end
    for (int i = 0; i < words; i++) begin
      if (i == gap_at) put_str("::");
      else if (i > 0) txt.push_back(":");
      put_hex_word();
    end
    if (gap_at == words) put_str("::");
    else if (dotted) txt.push_back(":");
    if (dotted) put_dotted();
  endfunction

  function automatic void corrupt();
    string pool = ":.0123456789abcdefgxG/ ";
    int p;
    if (txt.size() == 0) begin
      txt.push_back(pool[$urandom_range(0, pool.len() - 1)]);
      return;
    end
    p = $urandom_range(0, txt.size() - 1);
    case ($urandom_range(0, 4))
      0: txt[p] = pool[$urandom_range(0, pool.len() - 1)];
      1: txt.insert(p, pool[$urandom_range(0, pool.len() - 1)]);
      2: txt.delete(p);
      3: while (txt.size() > p) void'(txt.pop_back());
      default: txt[p] = 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_text(bit terminate);
    logic [7:0] ch;
    logic eot;
    for (int k = 0; k < txt.size(); k++) send_item(k == 0, txt[k], 1'b0, 1'b1);
    if (terminate) begin
      eot = 1'b0;
      case ($urandom_range(0, 3))
        0: begin
          eot = 1'b1;
          ch = 8'($urandom_range(0, 255));
        end
        1: ch = 8'd0;
        default: begin
          ch = sb.delim_char;
          if (sb.delim_any) begin
            ch = 8'($urandom_range(0, 255));
            while (addr_char(ch)) ch = 8'($urandom_range(0, 255));
          end
        end
      endcase
      send_item(txt.size() == 0, ch, eot, 1'b1);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          send_item(1'b0, 8'($urandom_range(0, 255)), 1'($urandom), 1'b0);
    end
    txt.delete();
  endtask

  task automatic random_sequence();
    int k;
    src_rate = 8 * $urandom_range(0, 3);
    k = $urandom_range(0, 99);
    if (k < 5) begin
      repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
      send_text(1'($urandom_range(0, 1)));
    end else begin
      if ((sb.family && $urandom_range(0, 9) != 0) || (!sb.family && $urandom_range(0, 9) == 0))
        put_v6();
      else
        put_dotted();
      if (k < 9) begin
        // drop the tail so the next start lands mid-address
        while (txt.size() > 1 && $urandom_range(0, 2) != 0) void'(txt.pop_back());
        send_text(1'b0);
      end else begin
        if ($urandom_range(0, 3) == 0) corrupt();
        if ($urandom_range(0, 7) == 0) corrupt();
        send_text(1'b1);
      end
    end
    if (!quiet && $urandom_range(0, 39) == 0) wait_idle();
  endtask

  initial begin
    int budget;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) wait_idle();
      set_config(ph_dc[p], ph_da[p], ph_fm[p]);
      if (p == 0) begin
        foreach (v6_cases[i]) begin
          put_str(v6_cases[i]);
          send_text(1'b1);
        end
        put_str("1:2:3");
        send_text(1'b0);
        put_str("::5");
        send_text(1'b1);
      end
      if (p == 3) begin
        foreach (v4_cases[i]) begin
          put_str(v4_cases[i]);
          send_text(1'b1);
        end
      end
      budget = sent + PER_PHASE;
      while (sent < budget) begin
        if (p == PHASES - 1 && sent >= budget - CALM_TAIL) quiet = 1'b1;
        random_sequence();
      end
    end
    wait_idle();
    if (sb.errors == 0 && sb.parsed_addrs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

[ip_address_text_parser_unit.f]
rtl/core/ipap_pkg.sv
rtl/core/ipap_front.sv
rtl/core/ipap_queue.sv
rtl/core/ipap_back.sv
rtl/core/ip_address_text_parser_unit.sv
tb/sv/testbench.sv
